### sv/fbop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbop_pkg
// Types, constants and helper functions shared by the notation parser blocks.
// ----------------------------------------------------------------------------
package fbop_pkg;

   localparam int unsigned NumClasses   = 13;
   localparam int unsigned QueueDepth   = 4;

   // token numbering, counted from one as tokens start
   localparam logic [2:0] TokNone    = 3'd0;
   localparam logic [2:0] TokBoard   = 3'd1;
   localparam logic [2:0] TokSide    = 3'd2;
   localparam logic [2:0] TokCastle  = 3'd3;
   localparam logic [2:0] TokPassant = 3'd4;
   localparam logic [2:0] TokMax     = 3'd7;

   localparam logic [7:0] CharSlash  = 8'h2F;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharTab    = 8'h09;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharW      = 8'h77;
   localparam logic [7:0] CharDash   = 8'h2D;
   localparam logic [7:0] CharUpK    = 8'h4B;
   localparam logic [7:0] CharUpQ    = 8'h51;
   localparam logic [7:0] CharLoK    = 8'h6B;
   localparam logic [7:0] CharLoQ    = 8'h71;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } fbop_req_type;

   typedef struct packed {
      logic        kind;
      logic [3:0]  square_class;
      logic [12:0] square_onehot;
      logic        white_to_move;
      logic        castle_white_king;
      logic        castle_white_queen;
      logic        castle_black_king;
      logic        castle_black_queen;
      logic        en_passant_set;
      logic        last_of_run;
   } fbop_rsp_type;

   typedef struct packed {
      logic white_to_move;
      logic castle_white_king;
      logic castle_white_queen;
      logic castle_black_king;
      logic castle_black_queen;
      logic en_passant_set;
   } fbop_flags_type;

   // one queue entry: a run of identical squares and an optional summary
   typedef struct packed {
      logic [3:0]     count;
      logic [3:0]     square_class;
      logic           summary;
      fbop_flags_type flags;
   } fbop_cmd_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
   endfunction

   function automatic logic [3:0] piece_class(input logic [7:0] c);
      logic [3:0] cls;
      case (c)
         8'h50: cls = 4'd1;   // P
         8'h4E: cls = 4'd2;   // N
         8'h42: cls = 4'd3;   // B
         8'h52: cls = 4'd4;   // R
         8'h51: cls = 4'd5;   // Q
         8'h4B: cls = 4'd6;   // K
         8'h70: cls = 4'd7;   // p
         8'h6E: cls = 4'd8;   // n
         8'h62: cls = 4'd9;   // b
         8'h72: cls = 4'd10;  // r
         8'h71: cls = 4'd11;  // q
         8'h6B: cls = 4'd12;  // k
         default: cls = 4'd0;
      endcase
      return cls;
   endfunction

endpackage

### sv/fbop_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbop_front
// Accepts text bytes, tracks tokens and flags, and queues square runs and
// summaries for the back end.
// ----------------------------------------------------------------------------
module fbop_front
   import fbop_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  fbop_req_type req_data,
   input  logic         q_full,
   output logic         q_push,
   output fbop_cmd_type q_data
);

   logic [2:0] tok_idx_ff, tok_idx_in;
   logic       in_tok_ff, in_tok_in;
   logic [1:0] tok_len_ff, tok_len_in;
   logic       fcm_ff, fcm_in;
   logic       side_ff, side_in;
   logic [3:0] castle_ff, castle_in;
   logic       passant_ff, passant_in;

   logic       accept;
   logic [7:0] c;
   logic [3:0] run_count;
   logic [3:0] run_class;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;
   assign c        = req_data.char_code;

   always_comb begin
      tok_idx_in = tok_idx_ff;
      in_tok_in  = in_tok_ff;
      tok_len_in = tok_len_ff;
      fcm_in     = fcm_ff;
      side_in    = side_ff;
      castle_in  = castle_ff;
      passant_in = passant_ff;
      run_count  = 4'd0;
      run_class  = 4'd0;
      if (is_space(c)) begin
         in_tok_in = 1'b0;
      end else begin
         if (!in_tok_ff) begin
            in_tok_in = 1'b1;
            if (tok_idx_ff < TokMax) begin
               tok_idx_in = tok_idx_ff + 3'd1;
            end
            tok_len_in = 2'd0;
            fcm_in     = 1'b0;
         end
         if (tok_len_in < 2'd2) begin
            tok_len_in = tok_len_in + 2'd1;
         end
         case (tok_idx_in)
            TokBoard: begin
               if (c == CharSlash) begin
                  run_count = 4'd0;
               end else if ((c >= CharZero) && (c <= CharNine)) begin
                  // low nibble of an ascii digit is its value
                  run_count = c[3:0];
               end else begin
                  run_count = 4'd1;
                  run_class = piece_class(c);
               end
            end
            TokSide: begin
               if (tok_len_in == 2'd1) begin
                  fcm_in = (c == CharW);
               end
               side_in = (tok_len_in == 2'd1) && fcm_in;
            end
            TokCastle: begin
               castle_in = castle_ff | {c == CharLoQ, c == CharLoK, c == CharUpQ, c == CharUpK};
            end
            TokPassant: begin
               if (tok_len_in == 2'd1) begin
                  fcm_in = (c == CharDash);
               end
               passant_in = !((tok_len_in == 2'd1) && fcm_in);
            end
            default: begin
               run_count = 4'd0;
            end
         endcase
      end
   end

   always_comb begin
      q_data.count                    = run_count;
      q_data.square_class             = run_class;
      q_data.summary                  = req_data.last_char;
      q_data.flags.white_to_move      = side_in;
      q_data.flags.castle_white_king  = castle_in[0];
      q_data.flags.castle_white_queen = castle_in[1];
      q_data.flags.castle_black_king  = castle_in[2];
      q_data.flags.castle_black_queen = castle_in[3];
      q_data.flags.en_passant_set     = passant_in;
      q_push = accept && ((run_count != 4'd0) || req_data.last_char);
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.last_char)) begin
         // after the summary the next byte starts a fresh text
         tok_idx_ff <= TokNone;
         in_tok_ff  <= 1'b0;
         tok_len_ff <= 2'd0;
         fcm_ff     <= 1'b0;
         side_ff    <= 1'b0;
         castle_ff  <= 4'd0;
         passant_ff <= 1'b1;
      end else if (accept) begin
         tok_idx_ff <= tok_idx_in;
         in_tok_ff  <= in_tok_in;
         tok_len_ff <= tok_len_in;
         fcm_ff     <= fcm_in;
         side_ff    <= side_in;
         castle_ff  <= castle_in;
         passant_ff <= passant_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last_char) |=> (tok_idx_ff == TokNone) && passant_ff)
      else $error("parse state not cleared after last byte");
`endif

endmodule

### sv/fbop_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbop_queue
// Small first-in first-out buffer of commands between front and back end.
// ----------------------------------------------------------------------------
module fbop_queue
   import fbop_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  fbop_cmd_type wdata,
   output logic         full,
   input  logic         pop,
   output fbop_cmd_type rdata,
   output logic         empty
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

   fbop_cmd_type    mem [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == FullCnt);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("command pushed into full queue");
`endif

endmodule

### sv/fbop_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbop_back
// Expands queued commands into square and summary results, one per cycle,
// into the result register while that register is free or being popped.
// ----------------------------------------------------------------------------
module fbop_back
   import fbop_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  fbop_cmd_type q_rdata,
   output logic         q_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output fbop_rsp_type rsp_data
);

   logic         busy_ff, busy_in;
   logic [3:0]   rem_ff, rem_in;
   fbop_cmd_type cmd_ff, cmd_in;
   logic         rsp_valid_ff, rsp_valid_in;
   fbop_rsp_type rsp_data_ff, rsp_data_in;

   logic         out_free;
   logic         emit;
   logic         finish;
   fbop_rsp_type result;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_pop;
      emit     = busy_ff && out_free;
      // last beat of a command: summary, or final square when no summary
      finish   = emit && ((rem_ff == 4'd0) || ((rem_ff == 4'd1) && !cmd_ff.summary));
      q_pop    = !q_empty && (!busy_ff || finish);

      busy_in = busy_ff;
      rem_in  = rem_ff;
      cmd_in  = cmd_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         rem_in  = q_rdata.count;
         cmd_in  = q_rdata;
      end else begin
         if (finish) begin
            busy_in = 1'b0;
         end
         if (emit && (rem_ff != 4'd0)) begin
            rem_in = rem_ff - 4'd1;
         end
      end
   end

   always_comb begin
      result = '0;
      if (rem_ff != 4'd0) begin
         result.kind          = 1'b0;
         result.square_class  = cmd_ff.square_class;
         result.square_onehot = 13'(1) << cmd_ff.square_class;
         result.last_of_run   = (rem_ff == 4'd1) && !cmd_ff.summary;
      end else begin
         result.kind               = 1'b1;
         result.white_to_move      = cmd_ff.flags.white_to_move;
         result.castle_white_king  = cmd_ff.flags.castle_white_king;
         result.castle_white_queen = cmd_ff.flags.castle_white_queen;
         result.castle_black_king  = cmd_ff.flags.castle_black_king;
         result.castle_black_queen = cmd_ff.flags.castle_black_queen;
         result.en_passant_set     = cmd_ff.flags.en_passant_set;
         result.last_of_run        = 1'b1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = emit ? result : rsp_data_ff;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rem_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   a_empty_run_has_summary: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (rem_ff == 4'd0)) |-> cmd_ff.summary)
      else $error("active command with nothing left to emit");
   a_summary_ends_run: assert property (@(posedge clock) disable iff (reset)
      (emit && (rem_ff == 4'd0)) |=> (!rsp_empty && rsp_data.kind && rsp_data.last_of_run))
      else $error("summary beat not marked as end of run");
   a_no_pop_mid_run: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !finish) |-> !q_pop)
      else $error("command loaded while previous one still running");
`endif

endmodule

### sv/fen_board_onehot_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fen_board_onehot_parser
// Position-notation text parser producing one-hot square classes and flags.
// ----------------------------------------------------------------------------
// Usage: push one text byte per beat on req_ (push/full), with last_char on
// the final byte. Results are popped from rsp_ (empty/pop): one beat per board
// square (a digit gives that many empty squares) and, on the last byte, one
// summary beat with side, castling and en-passant flags. last_of_run marks
// the final result beat caused by each input byte.
// A byte's results pass through the command queue, the back end's command
// register and the result register. Input runs at one byte per cycle while
// the command queue has room; the back end emits one result per cycle while
// the receiver pops, so a digit d holds the back end for d results and a run
// of digits fills the queue and raises req_full. The queue depth
// (QUEUE_DEPTH) sets how far input runs ahead. Reset clears the parse state,
// the queue and the result register; no beat is lost when the receiver
// stalls: the result register holds its beat and the queue, then req_full, back up behind it.
// ----------------------------------------------------------------------------
module fen_board_onehot_parser
   import fbop_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  fbop_req_type req_data,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output fbop_rsp_type rsp_data
);

   logic         q_push, q_full, q_pop, q_empty;
   fbop_cmd_type q_wdata, q_rdata;

   fbop_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   fbop_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   fbop_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

### verif/tb_fen_board_onehot_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fen_board_onehot_parser
// Self-checking bench for the position-notation parser. Short directed texts
// cover every piece letter, the digit extremes, unknown bytes and all summary
// flags. Random texts follow, mostly well-formed notation with random content
// and some raw byte noise. Both queues idle and stall at random, and one long
// receiver hold-off backs the block up into its input. An in-bench parse
// model predicts every result beat, and each popped beat is compared field by
// field.
// ----------------------------------------------------------------------------
module tb_fen_board_onehot_parser;
   import fbop_pkg::*;

   localparam int   ClockHalf   = 4;
   localparam int   ResetCycles = 12;
   localparam int   CycleLimit  = 300000;
   localparam int   HoldCycles  = 120;
   localparam int   EndSettle   = 16;
   localparam int   PhaseItems  = 60;
   localparam logic KindSquare  = 1'b0;
   localparam logic KindSummary = 1'b1;
   localparam logic [7:0] PieceOrder [12] =
      '{"P", "N", "B", "R", "Q", "K", "p", "n", "b", "r", "q", "k"};

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_push  = 1'b0;
   logic         req_full;
   fbop_req_type req_data  = '0;
   logic         rsp_empty;
   logic         rsp_pop   = 1'b0;
   fbop_rsp_type rsp_data;

   fbop_req_type text_bytes [$];
   logic [7:0]   text_buf [$];
   fbop_rsp_type results_due [$];

   int   sender_idle_pct = 0;
   int   recv_idle_pct   = 0;
   int   mismatches      = 0;
   int   cycle_count     = 0;
   int   beats_out       = 0;
   int   bytes_queued    = 0;
   int   hold_left       = 0;
   logic hold_armed      = 1'b0;
   logic hold_done       = 1'b0;
   logic req_beat_taken  = 1'b0;

   // parse state of the prediction
   logic [2:0] pos_token     = TokNone;
   logic       pos_in_token  = 1'b0;
   logic [1:0] pos_token_len = 2'd0;
   logic       pos_first_hit = 1'b0;
   logic       pos_side      = 1'b0;
   logic [3:0] pos_castle    = 4'd0;
   logic       pos_passant   = 1'b1;

   fen_board_onehot_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #(ClockHalf) clock = ~clock;

   function automatic logic [3:0] class_of(input logic [7:0] c);
      logic [3:0] cls;
      cls = 4'd0;
      for (int i = 0; i < 12; i++) begin
         if (PieceOrder[i] == c) cls = 4'(i + 1);
      end
      return cls;
   endfunction

   task automatic parse_char(input fbop_req_type beat);
      logic [7:0]   c;
      logic [3:0]   cls;
      int           n_sq;
      int           n_out;
      fbop_rsp_type r;
      c    = beat.char_code;
      cls  = 4'd0;
      n_sq = 0;
      if (c == CharSpace || (c >= CharTab && c <= CharCr)) begin
         pos_in_token = 1'b0;
      end else begin
         if (!pos_in_token) begin
            pos_in_token  = 1'b1;
            if (pos_token != TokMax) pos_token = pos_token + 3'd1;
            pos_token_len = 2'd0;
            pos_first_hit = 1'b0;
         end
         if (pos_token_len < 2'd2) pos_token_len = pos_token_len + 2'd1;
         case (pos_token)
            TokBoard: begin
               if (c >= CharZero && c <= CharNine) begin
                  n_sq = int'(c - CharZero);
               end else if (c != CharSlash) begin
                  n_sq = 1;
                  cls  = class_of(c);
               end
            end
            TokSide: begin
               if (pos_token_len == 2'd1) pos_first_hit = (c == CharW);
               pos_side = (pos_token_len == 2'd1) && pos_first_hit;
            end
            TokCastle: begin
               if (c == CharUpK) pos_castle[0] = 1'b1;
               if (c == CharUpQ) pos_castle[1] = 1'b1;
               if (c == CharLoK) pos_castle[2] = 1'b1;
               if (c == CharLoQ) pos_castle[3] = 1'b1;
            end
            TokPassant: begin
               if (pos_token_len == 2'd1) pos_first_hit = (c == CharDash);
               pos_passant = !((pos_token_len == 2'd1) && pos_first_hit);
            end
            default: begin
            end
         endcase
      end

      n_out = n_sq + (beat.last_char ? 1 : 0);
      for (int i = 0; i < n_out; i++) begin
         r = '0;
         if (i < n_sq) begin
            r.kind          = KindSquare;
            r.square_class  = cls;
            r.square_onehot = 13'd1 << cls;
         end else begin
            r.kind               = KindSummary;
            r.white_to_move      = pos_side;
            r.castle_white_king  = pos_castle[0];
            r.castle_white_queen = pos_castle[1];
            r.castle_black_king  = pos_castle[2];
            r.castle_black_queen = pos_castle[3];
            r.en_passant_set     = pos_passant;
         end
         r.last_of_run = (i == n_out - 1);
         results_due = {results_due, r};
      end

      // a summary starts a fresh text
      if (beat.last_char) begin
         pos_token     = TokNone;
         pos_in_token  = 1'b0;
         pos_token_len = 2'd0;
         pos_first_hit = 1'b0;
         pos_side      = 1'b0;
         pos_castle    = 4'd0;
         pos_passant   = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic check_field(input string fld, input logic [12:0] got,
                              input logic [12:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s got %0h want %0h",
                                   beats_out, fld, got, want));
   endtask

   task automatic check_result(input fbop_rsp_type got);
      fbop_rsp_type want;
      if (results_due.size() == 0) begin
         report_mismatch($sformatf("beat %0d not expected: %h", beats_out, got));
      end else begin
         want = results_due.pop_front();
         check_field("kind", got.kind, want.kind);
         check_field("square_class", got.square_class, want.square_class);
         check_field("square_onehot", got.square_onehot, want.square_onehot);
         check_field("white_to_move", got.white_to_move, want.white_to_move);
         check_field("castle_white_king", got.castle_white_king,
                     want.castle_white_king);
         check_field("castle_white_queen", got.castle_white_queen,
                     want.castle_white_queen);
         check_field("castle_black_king", got.castle_black_king,
                     want.castle_black_king);
         check_field("castle_black_queen", got.castle_black_queen,
                     want.castle_black_queen);
         check_field("en_passant_set", got.en_passant_set, want.en_passant_set);
         check_field("last_of_run", got.last_of_run, want.last_of_run);
      end
      beats_out++;
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         req_beat_taken = req_push && !req_full;
         if (req_beat_taken) parse_char(req_data);
         if (rsp_pop && !rsp_empty) check_result(rsp_data);
      end
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (!req_push || req_beat_taken) begin
         if (text_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_data <= text_bytes.pop_front();
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset || hold_left != 0) rsp_pop <= 1'b0;
      else rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // text building
   task automatic put_byte(input logic [7:0] c);
      text_buf = {text_buf, c};
   endtask

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) text_buf = {text_buf, 8'(s[i])};
   endtask

   task automatic flush_text();
      fbop_req_type beat;
      for (int i = 0; i < text_buf.size(); i++) begin
         beat.char_code = text_buf[i];
         beat.last_char = (i == text_buf.size() - 1);
         text_bytes = {text_bytes, beat};
      end
      bytes_queued += text_buf.size();
      text_buf.delete();
   endtask

   function automatic logic [7:0] ws_byte();
      if ($urandom_range(0, 2) == 0) return 8'($urandom_range(CharTab, CharCr));
      return CharSpace;
   endfunction

   function automatic logic [7:0] printable();
      return 8'($urandom_range(8'h21, 8'h7E));
   endfunction

   function automatic logic [7:0] board_byte();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 8) return PieceOrder[$urandom_range(0, 11)];
      if (sel < 13) return 8'($urandom_range(CharZero, CharNine));
      if (sel < 16) return CharSlash;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic gen_text();
      int    n;
      int    sel;
      int    n_tok;
      string castle_letters;
      castle_letters = "KQkq";
      if ($urandom_range(0, 9) == 0) begin
         // raw noise
         n = $urandom_range(1, 8);
         repeat (n) put_byte(8'($urandom_range(0, 255)));
      end else begin
         if ($urandom_range(0, 4) == 0) put_byte(ws_byte());
         n = $urandom_range(1, 10);
         repeat (n) put_byte(board_byte());
         sel   = $urandom_range(0, 9);
         n_tok = (sel < 1) ? 0 : (sel < 2) ? 1 : (sel < 3) ? 2 : (sel < 9) ? 3 : 4;
         for (int t = 1; t <= n_tok; t++) begin
            put_byte(ws_byte());
            if ($urandom_range(0, 3) == 0) put_byte(ws_byte());
            sel = $urandom_range(0, 19);
            case (t)
               1: begin
                  if (sel < 12) put_byte(CharW);
                  else if (sel < 16) put_str("b");
                  else if (sel < 18) begin
                     put_byte(CharW);
                     put_byte(printable());
                  end else put_byte(printable());
               end
               2: begin
                  if (sel < 3) begin
                     put_byte(CharDash);
                  end else begin
                     n = $urandom_range(1, 4);
                     repeat (n) begin
                        if ($urandom_range(0, 5) == 0) put_byte(printable());
                        else put_byte(castle_letters[$urandom_range(0, 3)]);
                     end
                  end
               end
               3: begin
                  if (sel < 10) put_byte(CharDash);
                  else if (sel < 15) begin
                     put_byte(8'($urandom_range("a", "h")));
                     put_byte(8'($urandom_range("1", "8")));
                  end else if (sel < 18) begin
                     put_byte(CharDash);
                     put_byte(printable());
                  end else put_byte(printable());
               end
               default: begin
                  n = $urandom_range(1, 3);
                  repeat (n) put_byte(printable());
               end
            endcase
         end
         // sometimes the final byte is whitespace
         if ($urandom_range(0, 3) == 0) put_byte(ws_byte());
      end
      flush_text();
   endtask

   task automatic drain();
      while (text_bytes.size() != 0 || req_push || results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct);
      int target;
      sender_idle_pct = send_pct;
      recv_idle_pct   = recv_pct;
      target = bytes_queued + PhaseItems;
      while (bytes_queued < target) gen_text();
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every piece, digit extremes, skip, unknown byte, all flags
      sender_idle_pct = 33;
      recv_idle_pct   = 53;
      put_str("PNBRQKpnbrqk09/");
      put_byte(8'hFF);
      put_byte(CharTab);
      put_byte(CharW);
      put_byte(CharCr);
      put_str("KQkq");
      put_byte(CharSpace);
      put_byte(CharDash);
      flush_text();
      // whitespace on the last byte, side and later tokens missing
      put_str("8");
      put_byte(8'h0B);
      flush_text();

      random_phase(33, 53);
      drain();
      random_phase(53, 33);
      drain();
      // no idling, with the long hold-off backing the block up
      hold_armed = 1'b1;
      random_phase(0, 0);
      drain();

      repeat (EndSettle) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
